/* rtl/permu_pkg.sv */
// permu_pkg: shared widths, control structs and the reciprocal table
// for the permutation unrank block. No dependencies.
package permu_pkg;

  localparam int RankWidth   = 29;
  localparam int ElemWidth   = 4;
  localparam int MaxElements = 12;
  localparam int RecipWidth  = 32;
  localparam int ProdWidth   = RankWidth + RecipWidth;
  localparam int RemWidth    = 5;

  // per-step control broadcast along the row of cells
  typedef struct packed {
    logic                 load;
    logic                 shift;
    logic [ElemWidth-1:0] count;
    logic [ElemWidth-1:0] pick;
  } cell_ctl_t;

  // divide request and result
  typedef struct packed {
    logic                 valid;
    logic [RankWidth-1:0] dividend;
    logic [ElemWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [RankWidth-1:0] quot;
    logic [ElemWidth-1:0] rem;
  } div_rsp_t;

  // floor((2^32 - 1) / d), estimate is then off by at most one
  function automatic logic [RecipWidth-1:0] recip(input logic [ElemWidth-1:0] d);
    logic [RecipWidth-1:0] m;
    unique case (d)
      4'd2:    m = 32'h7FFF_FFFF;
      4'd3:    m = 32'h5555_5555;
      4'd4:    m = 32'h3FFF_FFFF;
      4'd5:    m = 32'h3333_3333;
      4'd6:    m = 32'h2AAA_AAAA;
      4'd7:    m = 32'h2492_4924;
      4'd8:    m = 32'h1FFF_FFFF;
      4'd9:    m = 32'h1C71_C71C;
      4'd10:   m = 32'h1999_9999;
      4'd11:   m = 32'h1745_D174;
      4'd12:   m = 32'h1555_5555;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* rtl/permutation_unrank.sv */
// permutation_unrank: top level, turns a rank into permutation elements.
// Instantiates permu_div and a row of permu_cell; uses permu_pkg.
//
//  channel   | dir | payload
//  ----------+-----+-------------------------------------------------
//  s_axis    | in  | tdata[28:0] rank
//  m_axis    | out | tdata[3:0] element, tdata[7:4] position, tlast
//  cfg       | in  | cfg_wdata_i element count, written on cfg_we_i
//
// a new rank is accepted only after the last element of its item is emitted:
// each element takes a multiply step and a correct-and-emit step, set by
// the two-stage reciprocal divider. the first multiply overlaps the accept.
// a stalled output holds the emit step; no clearing pass after reset.
module permutation_unrank #(
  parameter int MAX_ELEMENTS = permu_pkg::MaxElements
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // rank in [28:0], zeros above
  input  logic [31:0]                        s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // element in [3:0], position in [7:4]
  output logic [7:0]                         m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we_i,
  input  logic [permu_pkg::ElemWidth-1:0]    cfg_wdata_i
);

  localparam logic [permu_pkg::ElemWidth-1:0] MaxCount =
    permu_pkg::ElemWidth'(MAX_ELEMENTS);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMul  = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [permu_pkg::ElemWidth-1:0] count_q;
  logic [permu_pkg::ElemWidth-1:0] n_eff;
  logic [permu_pkg::ElemWidth-1:0] live_q, live_d;
  logic [permu_pkg::ElemWidth-1:0] pos_q, pos_d;
  logic [permu_pkg::RankWidth-1:0] rank_q, rank_d;
  logic                            out_valid_q, out_valid_d;
  logic [permu_pkg::ElemWidth-1:0] out_elem_q, out_elem_d;
  logic [permu_pkg::ElemWidth-1:0] out_pos_q, out_pos_d;
  logic                            out_last_q, out_last_d;

  logic                            accept;
  logic                            emit;
  logic [permu_pkg::ElemWidth-1:0] pick;
  logic [permu_pkg::ElemWidth-1:0] picked;
  permu_pkg::div_req_t             div_req;
  permu_pkg::div_rsp_t             div_rsp;
  permu_pkg::cell_ctl_t            cell_ctl;

  logic [permu_pkg::ElemWidth-1:0] cell_value [MAX_ELEMENTS];
  logic [permu_pkg::ElemWidth-1:0] cell_pick  [MAX_ELEMENTS];

  // element count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd12;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // zero counts as one, large counts saturate
  always_comb begin
    n_eff = count_q;
    if (count_q == '0) begin
      n_eff = 4'd1;
    end else if (count_q > MaxCount) begin
      n_eff = MaxCount;
    end
  end

  // handshake and step qualifiers
  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign emit          = (state_q == StEmit) && (!out_valid_q || m_axis_tready);

  // divider request, straight from the input word on accept
  always_comb begin
    div_req.valid    = accept || (state_q == StMul);
    div_req.dividend = accept ? s_axis_tdata[permu_pkg::RankWidth-1:0] : rank_q;
    div_req.divisor  = accept ? n_eff : live_q;
  end

  permu_div u_div (
    .clk_i (clk_i),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // list is stored reversed, so slot s lives in cell live-1-s
  assign pick = live_q - 4'd1 - div_rsp.rem;

  always_comb begin
    cell_ctl.load  = accept;
    cell_ctl.shift = emit;
    cell_ctl.count = n_eff;
    cell_ctl.pick  = pick;
  end

  // row of cells, each hands its entry to the lower neighbor per step
  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    if (k == MAX_ELEMENTS - 1) begin : g_end
      permu_cell #(.INDEX(k)) u_cell (
        .clk_i   (clk_i),
        .ctl_i   (cell_ctl),
        .right_i (cell_value[k]),
        .tail_i  (cell_value[0]),
        .value_o (cell_value[k]),
        .pick_o  (cell_pick[k])
      );
    end else begin : g_mid
      permu_cell #(.INDEX(k)) u_cell (
        .clk_i   (clk_i),
        .ctl_i   (cell_ctl),
        .right_i (cell_value[k+1]),
        .tail_i  (cell_value[0]),
        .value_o (cell_value[k]),
        .pick_o  (cell_pick[k])
      );
    end
  end

  // picked element, only the selected cell drives nonzero
  always_comb begin
    picked = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      picked = picked | cell_pick[k];
    end
  end

  // step sequencer and output word register
  always_comb begin
    state_d     = state_q;
    live_d      = live_q;
    pos_d       = pos_q;
    rank_d      = rank_q;
    out_valid_d = out_valid_q;
    out_elem_d  = out_elem_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          live_d  = n_eff;
          pos_d   = '0;
          state_d = StEmit;
        end
      end
      StMul: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (emit) begin
          out_valid_d = 1'b1;
          out_elem_d  = picked;
          out_pos_d   = pos_q;
          out_last_d  = (live_q == 4'd1);
          rank_d      = div_rsp.quot;
          live_d      = live_q - 4'd1;
          pos_d       = pos_q + 4'd1;
          state_d     = (live_q == 4'd1) ? StIdle : StMul;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      live_q      <= '0;
      pos_q       <= '0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      pos_q       <= pos_d;
      rank_q      <= rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_elem_q <= out_elem_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pos_q, out_elem_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  // a step never runs with an empty list
  a_live_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (live_q != '0))
    else $error("emit step with no live entries");

  // corrected remainder always selects a live slot
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (div_rsp.rem < live_q))
    else $error("divider remainder out of range");

  // the flagged word sits at the last position of the item
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (out_pos_q == n_eff - 4'd1))
    else $error("last word at wrong position");

  // an accepted rank starts its first emit step right away
  a_accept_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StEmit) && (pos_q == '0))
    else $error("accept did not start the item");
`endif

endmodule

/* rtl/permu_cell.sv */
// permu_cell: one entry of the working list, kept in reversed order so
// that the tail entry always sits in cell zero. Depends on permu_pkg.
module permu_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk_i,
  input  permu_pkg::cell_ctl_t              ctl_i,
  input  logic [permu_pkg::ElemWidth-1:0]   right_i,
  input  logic [permu_pkg::ElemWidth-1:0]   tail_i,
  output logic [permu_pkg::ElemWidth-1:0]   value_o,
  output logic [permu_pkg::ElemWidth-1:0]   pick_o
);

  localparam logic [permu_pkg::ElemWidth-1:0] OwnIdx  = permu_pkg::ElemWidth'(INDEX);
  localparam logic [permu_pkg::ElemWidth-1:0] NextIdx = permu_pkg::ElemWidth'(INDEX + 1);

  logic [permu_pkg::ElemWidth-1:0] value_q, value_d;

  // identity load, shift toward cell zero, or take the tail into the hole
  always_comb begin
    value_d = value_q;
    if (ctl_i.load) begin
      value_d = ctl_i.count - OwnIdx - 4'd1;
    end else if (ctl_i.shift) begin
      value_d = (ctl_i.pick == NextIdx) ? tail_i : right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // contribute to the picked element only when selected
  assign value_o = value_q;
  assign pick_o  = (ctl_i.pick == OwnIdx) ? value_q : '0;

endmodule

/* rtl/permu_div.sv */
// permu_div: divides the running rank by a small divisor (1..12) with a
// registered reciprocal multiply and a one-step correction. Uses permu_pkg.
module permu_div (
  input  logic                  clk_i,
  input  permu_pkg::div_req_t   req_i,
  output permu_pkg::div_rsp_t   rsp_o
);

  logic [permu_pkg::ProdWidth-1:0] prod_q;
  logic [permu_pkg::RankWidth-1:0] dividend_q;
  logic [permu_pkg::ElemWidth-1:0] divisor_q;

  logic [permu_pkg::RankWidth-1:0] q_est;
  logic [8:0]                      qd_low;
  logic [permu_pkg::RemWidth-1:0]  rem_raw;
  logic [permu_pkg::RemWidth-1:0]  rem_fix;
  logic                            fix;

  // stage one: quotient estimate product
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prod_q     <= permu_pkg::ProdWidth'(req_i.dividend)
                  * permu_pkg::ProdWidth'(permu_pkg::recip(req_i.divisor));
      dividend_q <= req_i.dividend;
      divisor_q  <= req_i.divisor;
    end
  end

  // stage two: remainder from low bits only, it stays below twice the divisor
  always_comb begin
    q_est   = prod_q[permu_pkg::ProdWidth-1:permu_pkg::RecipWidth];
    qd_low  = 9'(q_est[permu_pkg::RemWidth-1:0]) * 9'(divisor_q);
    rem_raw = dividend_q[permu_pkg::RemWidth-1:0] - qd_low[permu_pkg::RemWidth-1:0];
    fix     = (rem_raw >= permu_pkg::RemWidth'(divisor_q));
    rem_fix = fix ? (rem_raw - permu_pkg::RemWidth'(divisor_q)) : rem_raw;
  end

  assign rsp_o.quot = q_est + permu_pkg::RankWidth'(fix);
  assign rsp_o.rem  = rem_fix[permu_pkg::ElemWidth-1:0];

endmodule
